// File: rtl/core/sva_pkg.sv
// ----------------------------------------------------------------------------
// sva_pkg: shared types and codes for the voice allocator
// Event and mode codes, held-note stack entry, stack command and result types.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int unsigned KEY_W   = 7;
  localparam int unsigned NOTE_W  = 14;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned VIDX_W  = 3;

  // input event codes
  localparam logic [1:0] ACT_NOTE_ON    = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF   = 2'd1;
  localparam logic [1:0] ACT_VOICE_DONE = 2'd2;

  // voice mode codes
  localparam logic [1:0] MODE_MONO   = 2'd0;
  localparam logic [1:0] MODE_POLY   = 2'd1;
  localparam logic [1:0] MODE_UNISON = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // voice command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {STK_NONE, STK_PUSH, STK_FILTER, STK_CLEAR} stk_op_e;
  typedef enum logic [1:0] {CELL_HOLD, CELL_SHIFT, CELL_HEAD, CELL_NEW} cell_sel_e;

  // one held note: note holds velocity in its upper half, pitch in its lower
  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [STAMP_W-1:0] stamp;
  } stk_entry_t;

  typedef struct packed {
    stk_op_e          op;
    logic [KEY_W-1:0] pitch;
    stk_entry_t       entry;
  } stk_ctrl_t;

  typedef struct packed {
    logic [VIDX_W-1:0] voice;
    logic              cmd;
    logic [KEY_W-1:0]  pitch;
    logic [KEY_W-1:0]  vel;
  } res_t;

endpackage

// File: rtl/core/synth_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator_core: polyphonic voice allocator, oldest-voice stealing
// Throughput: one event at a time, the next accepted the cycle after the
//   flush; the voice walk and the stack chain set it, output stalls add to it.
// Reset: mode poly, all voices silent, stack empty, note clock zero.
// ----------------------------------------------------------------------------
module synth_voice_allocator_core #(
  parameter int unsigned VOICES      = 8,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [6:0] pitch_i,
  input  logic [6:0] velocity_i,
  input  logic [2:0] finished_voice_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] voice_index_o,
  output logic       command_o,
  output logic [6:0] note_pitch_o,
  output logic [6:0] note_velocity_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_voice_mode_i
);

  localparam int unsigned VW     = $clog2(VOICES);
  localparam int unsigned SCW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned KW     = sva_pkg::KEY_W;
  localparam int unsigned SW     = sva_pkg::STAMP_W;
  localparam int unsigned VIDX_W = sva_pkg::VIDX_W;

  typedef enum logic [2:0] {ST_IDLE, ST_FILTER, ST_SCAN, ST_VOICE, ST_FLUSH} state_e;
  typedef enum logic [1:0] {LP_ALL, LP_ONE, LP_RESTART, LP_RELEASE} loop_e;

  // control and working registers
  state_e              state_q, state_d;
  loop_e               kind_q, kind_d;
  logic [1:0]          mode_q, mode_d;
  logic [VW-1:0]       idx_q, idx_d;
  logic [SCW-1:0]      step_q, step_d;
  logic [KW-1:0]       pitch_q, pitch_d;
  logic [2*KW-1:0]     note_q, note_d;
  logic [SW-1:0]       stamp_q, stamp_d;
  logic [SW-1:0]       clock_q, clock_d;
  logic [VW-1:0]       target_q, target_d;
  logic                sil_found_q, sil_found_d, rel_found_q, rel_found_d;
  logic [VW-1:0]       sil_idx_q, sil_idx_d, rel_idx_q, rel_idx_d, any_idx_q, any_idx_d;
  logic [SW-1:0]       sil_age_q, sil_age_d, rel_age_q, rel_age_d, any_age_q, any_age_d;
  sva_pkg::res_t       pend_q, pend_d, out_q, out_d;
  logic                pend_valid_q, pend_valid_d;
  logic                out_valid_q, out_valid_d, out_last_q, out_last_d;

  // voice bank
  logic [KW-1:0]       vpitch_q [VOICES];
  logic [KW-1:0]       vvel_q   [VOICES];
  logic [SW-1:0]       vage_q   [VOICES];
  logic [VOICES-1:0]   vheld_q, vsnd_q;

  logic                v_start, v_rel, v_done, v_clear;
  logic [VW-1:0]       fin_idx;
  logic                in_fire, cfg_fire, out_free, hit;
  logic [VW-1:0]       active_last;
  logic [KW-1:0]       cur_pitch, cur_vel;
  logic [SW-1:0]       cur_age;
  logic                cur_held, cur_snd;
  sva_pkg::res_t       cand;
  sva_pkg::stk_ctrl_t  stk_ctrl;
  logic [SCW-1:0]      stk_count;
  sva_pkg::stk_entry_t stk_top;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign active_last = (mode_q == sva_pkg::MODE_MONO) ? '0 : VW'(VOICES - 1);
  assign fin_idx     = VW'(finished_voice_i);

  assign cur_pitch = vpitch_q[idx_q];
  assign cur_vel   = vvel_q[idx_q];
  assign cur_age   = vage_q[idx_q];
  assign cur_held  = vheld_q[idx_q];
  assign cur_snd   = vsnd_q[idx_q];

  sva_held_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .count_o (stk_count),
    .top_o   (stk_top)
  );

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    mode_d       = mode_q;
    idx_d        = idx_q;
    step_d       = step_q;
    pitch_d      = pitch_q;
    note_d       = note_q;
    stamp_d      = stamp_q;
    clock_d      = clock_q;
    target_d     = target_q;
    sil_found_d  = sil_found_q;
    rel_found_d  = rel_found_q;
    sil_idx_d    = sil_idx_q;
    rel_idx_d    = rel_idx_q;
    any_idx_d    = any_idx_q;
    sil_age_d    = sil_age_q;
    rel_age_d    = rel_age_q;
    any_age_d    = any_age_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    v_start      = 1'b0;
    v_rel        = 1'b0;
    v_done       = 1'b0;
    v_clear      = 1'b0;
    hit          = 1'b0;
    stk_ctrl.op          = sva_pkg::STK_NONE;
    stk_ctrl.pitch       = pitch_q;
    stk_ctrl.entry.note  = {velocity_i, pitch_i};
    stk_ctrl.entry.stamp = clock_q;

    cand.voice = VIDX_W'(idx_q);
    cand.cmd   = sva_pkg::CMD_START;
    cand.pitch = note_q[KW-1:0];
    cand.vel   = note_q[2*KW-1:KW];

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          if (cfg_voice_mode_i != sva_pkg::MODE_RSVD && cfg_voice_mode_i != mode_q) begin
            mode_d      = cfg_voice_mode_i;
            v_clear     = 1'b1;
            stk_ctrl.op = sva_pkg::STK_CLEAR;
          end
        end else if (in_fire) begin
          case (action_i)
            sva_pkg::ACT_NOTE_ON: begin
              note_d      = {velocity_i, pitch_i};
              stamp_d     = clock_q;
              clock_d     = clock_q + SW'(1);
              stk_ctrl.op = sva_pkg::STK_PUSH;
              idx_d       = '0;
              sil_found_d = 1'b0;
              rel_found_d = 1'b0;
              if (mode_q == sva_pkg::MODE_POLY) begin
                state_d = ST_SCAN;
              end else begin
                kind_d  = LP_ALL;
                state_d = ST_VOICE;
              end
            end
            sva_pkg::ACT_NOTE_OFF: begin
              pitch_d = pitch_i;
              step_d  = stk_count;
              state_d = ST_FILTER;
            end
            sva_pkg::ACT_VOICE_DONE: begin
              v_done = (32'(finished_voice_i) < VOICES);
            end
            default: ;
          endcase
        end
      end

      // one chain step per held entry
      ST_FILTER: begin
        if (step_q != '0) begin
          stk_ctrl.op = sva_pkg::STK_FILTER;
          step_d      = step_q - SCW'(1);
        end else begin
          idx_d   = '0;
          state_d = ST_VOICE;
          if (mode_q != sva_pkg::MODE_POLY && stk_count != '0) begin
            note_d  = stk_top.note;
            stamp_d = stk_top.stamp;
            kind_d  = LP_RESTART;
          end else begin
            kind_d  = LP_RELEASE;
          end
        end
      end

      // oldest silent / released / any voice, one voice per cycle
      ST_SCAN: begin
        if (!cur_snd && (!sil_found_q || cur_age < sil_age_q)) begin
          sil_found_d = 1'b1;
          sil_idx_d   = idx_q;
          sil_age_d   = cur_age;
        end
        if (!cur_held && (!rel_found_q || cur_age < rel_age_q)) begin
          rel_found_d = 1'b1;
          rel_idx_d   = idx_q;
          rel_age_d   = cur_age;
        end
        if (idx_q == '0 || cur_age < any_age_q) begin
          any_idx_d = idx_q;
          any_age_d = cur_age;
        end
        if (idx_q == VW'(VOICES - 1)) begin
          target_d = sil_found_d ? sil_idx_d : (rel_found_d ? rel_idx_d : any_idx_d);
          kind_d   = LP_ONE;
          idx_d    = '0;
          state_d  = ST_VOICE;
        end else begin
          idx_d = idx_q + VW'(1);
        end
      end

      // walk the active voices; one command held back to mark the last
      ST_VOICE: begin
        case (kind_q)
          LP_ALL:     hit = 1'b1;
          LP_ONE:     hit = (idx_q == target_q);
          LP_RESTART: hit = (cur_pitch != note_q[KW-1:0]);
          default: begin
            hit        = (cur_pitch == pitch_q) && cur_snd;
            cand.cmd   = sva_pkg::CMD_RELEASE;
            cand.pitch = cur_pitch;
            cand.vel   = cur_vel;
          end
        endcase
        if (!(hit && pend_valid_q && !out_free)) begin
          if (hit) begin
            v_rel   = (kind_q == LP_RELEASE);
            v_start = (kind_q != LP_RELEASE);
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_last_d  = 1'b0;
              out_valid_d = 1'b1;
            end
            pend_d       = cand;
            pend_valid_d = 1'b1;
          end
          if (idx_q == active_last) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + VW'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d        = pend_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= LP_ALL;
      mode_q       <= sva_pkg::MODE_POLY;
      idx_q        <= '0;
      step_q       <= '0;
      clock_q      <= '0;
      sil_found_q  <= 1'b0;
      rel_found_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      mode_q       <= mode_d;
      idx_q        <= idx_d;
      step_q       <= step_d;
      clock_q      <= clock_d;
      sil_found_q  <= sil_found_d;
      rel_found_q  <= rel_found_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    pitch_q   <= pitch_d;
    note_q    <= note_d;
    stamp_q   <= stamp_d;
    target_q  <= target_d;
    sil_idx_q <= sil_idx_d;
    rel_idx_q <= rel_idx_d;
    any_idx_q <= any_idx_d;
    sil_age_q <= sil_age_d;
    rel_age_q <= rel_age_d;
    any_age_q <= any_age_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  // voice bank update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        vpitch_q[i] <= '0;
        vvel_q[i]   <= '0;
        vage_q[i]   <= '0;
      end
      vheld_q <= '0;
      vsnd_q  <= '0;
    end else begin
      if (v_clear) begin
        vheld_q <= '0;
        vsnd_q  <= '0;
      end
      if (v_done) begin
        vheld_q[fin_idx] <= 1'b0;
        vsnd_q[fin_idx]  <= 1'b0;
      end
      if (v_start) begin
        vpitch_q[idx_q] <= note_q[KW-1:0];
        vvel_q[idx_q]   <= note_q[2*KW-1:KW];
        vage_q[idx_q]   <= stamp_q;
        vheld_q[idx_q]  <= 1'b1;
        vsnd_q[idx_q]   <= 1'b1;
      end
      if (v_rel) begin
        vheld_q[idx_q] <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign voice_index_o   = out_q.voice;
  assign command_o       = out_q.cmd;
  assign note_pitch_o    = out_q.pitch;
  assign note_velocity_o = out_q.vel;
  assign last_o          = out_last_q;

  // checks
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("held-back command left over in idle");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_count <= SCW'(STACK_DEPTH))
    else $error("held-note count beyond stack depth");

  a_mode_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && cfg_voice_mode_i != sva_pkg::MODE_RSVD && cfg_voice_mode_i != mode_q)
    |=> (stk_count == '0 && vsnd_q == '0 && vheld_q == '0))
    else $error("mode change did not clear stack and voices");

endmodule

// File: rtl/core/sva_stack_cell.sv
// ----------------------------------------------------------------------------
// sva_stack_cell: one entry of the held-note chain
// Holds, takes its upper neighbor, takes the chain head or loads a new note.
// ----------------------------------------------------------------------------
module sva_stack_cell (
  input  logic                  clk_i,
  input  sva_pkg::cell_sel_e    sel_i,
  input  sva_pkg::stk_entry_t   shift_i,
  input  sva_pkg::stk_entry_t   head_i,
  input  sva_pkg::stk_entry_t   new_i,
  output sva_pkg::stk_entry_t   entry_o
);

  sva_pkg::stk_entry_t entry_q, entry_d;

  // source select
  always_comb begin
    case (sel_i)
      sva_pkg::CELL_SHIFT: entry_d = shift_i;
      sva_pkg::CELL_HEAD:  entry_d = head_i;
      sva_pkg::CELL_NEW:   entry_d = new_i;
      default:             entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/core/sva_held_stack.sv
// ----------------------------------------------------------------------------
// sva_held_stack: held-note stack as a chain of cells
// Cell 0 is the oldest note. A filter step pops the head and re-appends it at
// the top of the live region unless its pitch matches; count steps compact.
// ----------------------------------------------------------------------------
module sva_held_stack #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sva_pkg::stk_ctrl_t            ctrl_i,
  output logic [$clog2(DEPTH+1)-1:0]    count_o,
  output sva_pkg::stk_entry_t           top_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       top_sub;
  logic                full;
  logic                keep;
  sva_pkg::stk_entry_t head;
  sva_pkg::stk_entry_t entry [DEPTH];
  sva_pkg::cell_sel_e  sel [DEPTH];

  assign head = entry[0];
  assign full = (count_q == CW'(DEPTH));
  assign keep = (head.note[sva_pkg::KEY_W-1:0] != ctrl_i.pitch);

  // per-cell select and the chain itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned NXT = (i < DEPTH - 1) ? i + 1 : i;

    always_comb begin
      sel[i] = sva_pkg::CELL_HOLD;
      case (ctrl_i.op)
        sva_pkg::STK_PUSH: begin
          if (full) begin
            sel[i] = (i == DEPTH - 1) ? sva_pkg::CELL_NEW : sva_pkg::CELL_SHIFT;
          end else if (count_q == CW'(i)) begin
            sel[i] = sva_pkg::CELL_NEW;
          end
        end
        sva_pkg::STK_FILTER: begin
          if (CW'(i + 1) < count_q) begin
            sel[i] = sva_pkg::CELL_SHIFT;
          end else if (CW'(i + 1) == count_q && keep) begin
            sel[i] = sva_pkg::CELL_HEAD;
          end
        end
        default: ;
      endcase
    end

    sva_stack_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel[i]),
      .shift_i (entry[NXT]),
      .head_i  (head),
      .new_i   (ctrl_i.entry),
      .entry_o (entry[i])
    );
  end

  // fill count
  always_comb begin
    count_d = count_q;
    case (ctrl_i.op)
      sva_pkg::STK_PUSH:   if (!full) count_d = count_q + CW'(1);
      sva_pkg::STK_FILTER: if (count_q != '0 && !keep) count_d = count_q - CW'(1);
      sva_pkg::STK_CLEAR:  count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_sub = count_q - CW'(1);
  assign top_o   = entry[top_sub[IW-1:0]];
  assign count_o = count_q;

endmodule
